// File: hw/rtl/bsa_pkg.sv
package bsa_pkg;

    // control of the shift-add multiply-accumulate unit
    typedef struct packed {
        logic load;
        logic clear;
        logic step;
    } t_mac_ctl;

    // control of the shared restoring root / divide unit
    typedef struct packed {
        logic load_sqrt;
        logic load_div;
        logic step;
    } t_rd_ctl;

    // number of quotient bits of the centre move ratio
    localparam int unsigned T_FRAC = 32;

endpackage

// File: hw/rtl/bounding_sphere_accumulate.sv
// Running bounding sphere in signed fixed point. Each input beat clears the
// sphere, extends it by a point or merges another sphere (an unknown op keeps
// it), and yields one output beat with the new sphere. Trivial cases (clear,
// first operand, saturation, unset operand, unknown op) go straight to the
// output beat. A full grow runs on one shift-add multiply-accumulate unit and
// one restoring root/divide unit: the squared distance, the root, the distance
// tests, the move ratio and the centre moves; the squared distance ends sooner
// when the distance components are small. The input stalls while an item is in
// progress.
module bounding_sphere_accumulate #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_op,
    input  logic signed [COORD_WIDTH-1:0] i_in_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_y,
    input  logic signed [COORD_WIDTH-1:0] i_in_z,
    input  logic [COORD_WIDTH-2:0]       i_in_radius,
    input  logic                         i_in_empty,
    input  logic                         i_in_max,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_WIDTH-1:0] o_center_x,
    output logic signed [COORD_WIDTH-1:0] o_center_y,
    output logic signed [COORD_WIDTH-1:0] o_center_z,
    output logic [COORD_WIDTH-2:0]       o_radius,
    output logic                         o_is_empty,
    output logic                         o_is_max,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [15:0]                  i_cfg_data
);
    import bsa_pkg::*;

    localparam int unsigned CW  = COORD_WIDTH;
    localparam int unsigned AW  = (2 * CW + 2 > CW + T_FRAC + 2) ? 2 * CW + 2 : CW + T_FRAC + 2;
    localparam int unsigned BW  = (CW + 1 > T_FRAC + 1) ? CW + 1 : T_FRAC + 1;
    localparam int unsigned SW  = CW + 2;
    localparam int unsigned CNW = $clog2(((CW + 1 > T_FRAC) ? CW + 1 : T_FRAC) + 1);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_MERGE = 2'd2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQL  = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_ROOT = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_MVL  = 4'd6;
    localparam logic [3:0] S_MV   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam logic [CW-2:0] RMAX = '1;

    logic [3:0]           r_state;
    logic [1:0]           r_ax;
    logic [CNW-1:0]       r_cnt;
    logic                 r_tsat;
    logic [15:0]          r_tol;

    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic [CW-2:0]        r_cr;
    logic                 r_empty, r_max;

    logic signed [CW-1:0] r_px, r_py, r_pz;
    logic [CW-2:0]        r_r1;
    logic signed [CW:0]   r_dx, r_dy, r_dz;
    logic [CW-2:0]        r_grow_r;

    logic                 r_ovalid;
    logic signed [CW-1:0] r_ox, r_oy, r_oz;
    logic [CW-2:0]        r_or;
    logic                 r_oempty, r_omax;

    t_mac_ctl      mac_ctl;
    t_rd_ctl       rd_ctl;
    logic [AW-1:0] mac_a;
    logic [BW-1:0] mac_b;
    logic [AW-1:0] mac_acc;
    logic          mac_busy;
    logic [T_FRAC-1:0] rd_t;
    logic [CW:0]   dn;

    logic signed [CW:0] d_sel;
    logic [CW:0]        d_mag;
    logic [CW:0]        off;
    logic signed [CW:0] c_sel;
    logic signed [CW:0] c_new;

    logic [SW-1:0] sum_dr1, sum_dr0, sum_all, k_val, d2_val;
    logic          accept;
    logic          start_grow;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // operand needs the full grow sequence
    assign start_grow = !r_max && !r_empty && (i_op == OP_POINT ||
                        (i_op == OP_MERGE && !i_in_max && !i_in_empty));

    // operand selection for the current axis
    always_comb begin
        case (r_ax)
            2'd0:    begin d_sel = r_dx; c_sel = {r_cx[CW-1], r_cx}; end
            2'd1:    begin d_sel = r_dy; c_sel = {r_cy[CW-1], r_cy}; end
            default: begin d_sel = r_dz; c_sel = {r_cz[CW-1], r_cz}; end
        endcase
        d_mag = d_sel[CW] ? (CW+1)'(-d_sel) : d_sel;
        off   = mac_acc[CW+T_FRAC:T_FRAC];
        c_new = d_sel[CW] ? (c_sel - off) : (c_sel + off);
    end

    // unit control from the sequencer
    always_comb begin
        mac_ctl = '0;
        rd_ctl  = '0;
        mac_a   = AW'(d_mag);
        mac_b   = BW'(d_mag);
        case (r_state)
            S_SQL: begin
                mac_ctl.load  = 1'b1;
                mac_ctl.clear = (r_ax == 2'd0);
            end
            S_SQ: begin
                mac_ctl.step     = mac_busy;
                rd_ctl.load_sqrt = !mac_busy && (r_ax == 2'd2);
            end
            S_ROOT: rd_ctl.step = 1'b1;
            S_CHK:  rd_ctl.load_div = !(k_val >= d2_val);
            S_DIV:  rd_ctl.step = 1'b1;
            S_MVL: begin
                mac_ctl.load  = 1'b1;
                mac_ctl.clear = 1'b1;
                mac_b = r_tsat ? BW'({1'b1, {T_FRAC{1'b0}}}) : BW'(rd_t);
            end
            S_MV:   mac_ctl.step = mac_busy;
            default: ;
        endcase
    end

    // distance tests and grown radius
    always_comb begin
        sum_dr1 = SW'(dn) + SW'(r_r1);
        sum_dr0 = SW'(dn) + SW'(r_cr);
        sum_all = sum_dr1 + SW'(r_cr);
        k_val   = sum_dr1 - SW'(r_cr);
        d2_val  = {dn, 1'b0};
    end

    bsa_mac #(.AW(AW), .BW(BW)) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_acc  (mac_acc),
        .o_busy (mac_busy)
    );

    bsa_rootdiv #(.CW(CW)) u_rootdiv (
        .i_clk  (i_clk),
        .i_ctl  (rd_ctl),
        .i_n    (mac_acc[2*CW+1:0]),
        .i_k    (k_val),
        .i_d2   (d2_val),
        .o_t    (rd_t),
        .o_root (dn)
    );

    // sequencer and sphere state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ax     <= '0;
            r_cnt    <= '0;
            r_tsat   <= 1'b0;
            r_tol    <= 16'd1;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_cr     <= '0;
            r_empty  <= 1'b1;
            r_max    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
            // output beat valid
            if (r_state == S_FIN && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= start_grow ? S_SQL : S_FIN;
                        r_px <= i_in_x;
                        r_py <= i_in_y;
                        r_pz <= i_in_z;
                        r_dx <= (CW+1)'(i_in_x) - (CW+1)'(r_cx);
                        r_dy <= (CW+1)'(i_in_y) - (CW+1)'(r_cy);
                        r_dz <= (CW+1)'(i_in_z) - (CW+1)'(r_cz);
                        r_r1 <= (i_op == OP_MERGE) ? i_in_radius : '0;
                        r_ax <= '0;
                        if (i_op == OP_CLEAR) begin
                            r_cx    <= '0;
                            r_cy    <= '0;
                            r_cz    <= '0;
                            r_cr    <= '0;
                            r_empty <= 1'b1;
                            r_max   <= 1'b0;
                        end else if (!r_max && i_op == OP_MERGE && i_in_max) begin
                            r_cx    <= '0;
                            r_cy    <= '0;
                            r_cz    <= '0;
                            r_cr    <= RMAX;
                            r_max   <= 1'b1;
                            r_empty <= 1'b0;
                        end else if (!r_max && (i_op == OP_POINT ||
                                     (i_op == OP_MERGE && !i_in_empty))) begin
                            if (r_empty) begin
                                r_cx    <= i_in_x;
                                r_cy    <= i_in_y;
                                r_cz    <= i_in_z;
                                r_cr    <= (i_op == OP_MERGE) ? i_in_radius : '0;
                                r_empty <= 1'b0;
                            end
                        end
                    end
                end
                S_SQL: r_state <= S_SQ;
                S_SQ: begin
                    if (!mac_busy) begin
                        if (r_ax == 2'd2) begin
                            r_cnt   <= CNW'(CW + 1);
                            r_state <= S_ROOT;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_SQL;
                        end
                    end
                end
                S_ROOT: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNW'(1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_ax     <= '0;
                    r_grow_r <= (sum_all[SW-1:1] > (SW-1)'(RMAX)) ? RMAX : sum_all[CW-1:1];
                    r_tsat   <= (k_val >= d2_val);
                    r_cnt    <= CNW'(T_FRAC);
                    if (dn <= (CW+1)'(r_tol)) begin
                        if (r_r1 > r_cr) begin
                            r_cr <= r_r1;
                        end
                        r_state <= S_FIN;
                    end else if (sum_dr1 < SW'(r_cr)) begin
                        r_state <= S_FIN;
                    end else if (sum_dr0 < SW'(r_r1)) begin
                        r_cx    <= r_px;
                        r_cy    <= r_py;
                        r_cz    <= r_pz;
                        r_cr    <= r_r1;
                        r_state <= S_FIN;
                    end else if (k_val >= d2_val) begin
                        r_state <= S_MVL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNW'(1)) begin
                        r_state <= S_MVL;
                    end
                end
                S_MVL: r_state <= S_MV;
                S_MV: begin
                    if (!mac_busy) begin
                        case (r_ax)
                            2'd0:    r_cx <= c_new[CW-1:0];
                            2'd1:    r_cy <= c_new[CW-1:0];
                            default: r_cz <= c_new[CW-1:0];
                        endcase
                        if (r_ax == 2'd2) begin
                            r_cr    <= r_grow_r;
                            r_state <= S_FIN;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_MVL;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_ovalid || !i_stall)) begin
            r_ox     <= r_cx;
            r_oy     <= r_cy;
            r_oz     <= r_cz;
            r_or     <= r_cr;
            r_oempty <= r_empty;
            r_omax   <= r_max;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_center_x = r_ox;
    assign o_center_y = r_oy;
    assign o_center_z = r_oz;
    assign o_radius   = r_or;
    assign o_is_empty = r_oempty;
    assign o_is_max   = r_omax;

    // a saturated sphere reports centre zero and full radius
    a_max_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_max |-> o_radius == RMAX && o_center_x == '0 && !o_is_empty)
        else $error("saturated sphere malformed");

    // an empty sphere reports centre and radius zero
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_radius == '0 && o_center_y == '0 && o_center_z == '0)
        else $error("empty sphere malformed");

    // an accepted beat always occupies the sequencer next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("sequencer not busy after accept");

    // arithmetic units only run during a grow
    a_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE || r_state == S_FIN |-> !mac_ctl.step && !rd_ctl.step)
        else $error("unit stepping outside a grow");

endmodule

// File: hw/rtl/bsa_mac.sv
module bsa_mac #(
    parameter int unsigned AW = 66,
    parameter int unsigned BW = 33
) (
    input  logic             i_clk,
    input  bsa_pkg::t_mac_ctl i_ctl,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW-1:0]    o_acc,
    output logic             o_busy
);
    import bsa_pkg::*;

    logic [AW-1:0] r_ma;
    logic [BW-1:0] r_mb;
    logic [AW-1:0] r_acc;

    // one multiplier bit per cycle while stepped, lsb first, accumulating across loads unless cleared
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ma <= i_a;
            r_mb <= i_b;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end
        end else if (i_ctl.step) begin
            if (r_mb[0]) begin
                r_acc <= r_acc + r_ma;
            end
            r_ma <= {r_ma[AW-2:0], 1'b0};
            r_mb <= {1'b0, r_mb[BW-1:1]};
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = (r_mb != '0);

endmodule

// File: hw/rtl/bsa_rootdiv.sv
module bsa_rootdiv #(
    parameter int unsigned CW = 32
) (
    input  logic              i_clk,
    input  bsa_pkg::t_rd_ctl  i_ctl,
    input  logic [2*CW+1:0]   i_n,
    input  logic [CW+1:0]     i_k,
    input  logic [CW+1:0]     i_d2,
    output logic [bsa_pkg::T_FRAC-1:0] o_t,
    output logic [CW:0]       o_root
);
    import bsa_pkg::*;

    localparam int unsigned RW = CW + 4;
    localparam int unsigned QW = (CW + 1 > T_FRAC) ? CW + 1 : T_FRAC;

    logic            r_div;
    logic [RW-1:0]   r_rem;
    logic [QW-1:0]   r_q;
    logic [2*CW+1:0] r_n;
    logic [CW+1:0]   r_d2;

    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic [RW-1:0] diff;
    logic          ge;

    // shared trial subtract: two radicand bits per step, or one dividend bit
    always_comb begin
        if (r_div) begin
            cur   = {r_rem[RW-2:0], 1'b0};
            trial = RW'(r_d2);
        end else begin
            cur   = {r_rem[RW-3:0], r_n[2*CW+1:2*CW]};
            trial = RW'({r_q, 2'b01});
        end
        diff = cur - trial;
        ge   = (cur >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sqrt) begin
            r_div <= 1'b0;
            r_rem <= '0;
            r_q   <= '0;
            r_n   <= i_n;
        end else if (i_ctl.load_div) begin
            r_div <= 1'b1;
            r_rem <= RW'(i_k);
            r_q   <= '0;
            r_d2  <= i_d2;
        end else if (i_ctl.step) begin
            r_rem <= ge ? diff : cur;
            r_q   <= {r_q[QW-2:0], ge};
            r_n   <= {r_n[2*CW-1:0], 2'b00};
        end
    end

    assign o_t    = r_q[T_FRAC-1:0];
    assign o_root = r_q[CW:0];

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bsa_pkg::*;

    localparam int unsigned W = 32;
    localparam int unsigned N_RANDOM = 1030;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam logic [W-2:0] RAD_MAX = {(W-1){1'b1}};

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_EXTEND = 2'd1,
        OP_MERGE  = 2'd2,
        OP_NONE   = 2'd3
    } t_sphere_op;

    typedef struct {
        t_sphere_op op;
        logic signed [W-1:0] x, y, z;
        logic [W-2:0] r;
        logic empty, max;
    } t_operand;

    typedef struct {
        logic signed [W-1:0] x, y, z;
        logic [W-2:0] r;
        logic empty, max;
    } t_sphere;

    // sphere predictor and store of expected spheres
    class sphere_scoreboard;
        longint cx, cy, cz;
        logic [63:0] crad;
        logic empty_f, max_f;
        logic [63:0] tol;
        t_sphere pending[$];
        int unsigned mismatches, checked;
        int unsigned n_grow, n_cover, n_covered, n_coinc, n_sat;

        function new();
            clear_state();
            tol = 1;
        endfunction

        function void clear_state();
            cx = 0; cy = 0; cz = 0; crad = 0;
            empty_f = 1; max_f = 0;
        endfunction

        function logic [63:0] magnitude(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint shift_axis(longint c0, longint d, logic [63:0] t);
            logic [127:0] p;
            logic [63:0] off;
            p = 128'(magnitude(d)) * 128'(t);
            off = p[95:32];
            return d < 0 ? c0 - longint'(off) : c0 + longint'(off);
        endfunction

        // smallest sphere taking in the operand
        function void grow(longint x, longint y, longint z, logic [63:0] r1);
            longint dx, dy, dz;
            logic [127:0] sq, tt;
            logic [63:0] dn, tr, cr, k, d2, t, rem, r0;
            dx = x - cx; dy = y - cy; dz = z - cz;
            r0 = crad;
            sq = 128'(magnitude(dx)) * 128'(magnitude(dx))
               + 128'(magnitude(dy)) * 128'(magnitude(dy))
               + 128'(magnitude(dz)) * 128'(magnitude(dz));
            dn = 0;
            for (int b = W; b >= 0; b--) begin
                tr = dn | (64'd1 << b);
                tt = 128'(tr) * 128'(tr);
                if (tt <= sq) dn = tr;
            end
            if (dn <= tol) begin
                n_coinc++;
                if (r1 > r0) crad = r1;
                return;
            end
            if (dn + r1 < r0) begin
                n_covered++;
                return;
            end
            if (dn + r0 < r1) begin
                n_cover++;
                cx = x; cy = y; cz = z; crad = r1;
                return;
            end
            n_grow++;
            cr = (dn + r0 + r1) >> 1;
            if (cr > 64'(RAD_MAX)) cr = 64'(RAD_MAX);
            k = dn + r1 - r0;
            d2 = dn << 1;
            if (k >= d2) begin
                t = 64'd1 << 32;
            end else begin
                rem = k;
                t = 0;
                for (int i = 0; i < T_FRAC; i++) begin
                    rem = rem << 1;
                    t = t << 1;
                    if (rem >= d2) begin
                        rem = rem - d2;
                        t = t | 64'd1;
                    end
                end
            end
            cx = shift_axis(cx, dx, t);
            cy = shift_axis(cy, dy, t);
            cz = shift_axis(cz, dz, t);
            crad = cr;
        endfunction

        function void note_operand(t_operand a);
            t_sphere s;
            case (a.op)
                OP_CLEAR: clear_state();
                OP_EXTEND: begin
                    if (!max_f) begin
                        if (empty_f) begin
                            cx = a.x; cy = a.y; cz = a.z; crad = 0; empty_f = 0;
                        end else begin
                            grow(a.x, a.y, a.z, 0);
                        end
                    end
                end
                OP_MERGE: begin
                    if (!max_f) begin
                        if (a.max) begin
                            cx = 0; cy = 0; cz = 0; crad = 64'(RAD_MAX);
                            max_f = 1; empty_f = 0; n_sat++;
                        end else if (!a.empty) begin
                            if (empty_f) begin
                                cx = a.x; cy = a.y; cz = a.z; crad = 64'(a.r);
                                empty_f = 0;
                            end else begin
                                grow(a.x, a.y, a.z, 64'(a.r));
                            end
                        end
                    end
                end
                default: ;
            endcase
            s.x = cx[W-1:0]; s.y = cy[W-1:0]; s.z = cz[W-1:0];
            s.r = crad[W-2:0]; s.empty = empty_f; s.max = max_f;
            pending.push_back(s);
        endfunction

        function void check_sphere(t_sphere got);
            t_sphere e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output beat x=%0d r=%0d", got.x, got.r);
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.r !== e.r
                    || got.empty !== e.empty || got.max !== e.max) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: beat %0d expected c=(%0d,%0d,%0d) r=%0d e=%0b m=%0b",
                             checked, e.x, e.y, e.z, e.r, e.empty, e.max);
                    $display("       got      c=(%0d,%0d,%0d) r=%0d e=%0b m=%0b",
                             got.x, got.y, got.z, got.r, got.empty, got.max);
                end
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0, i_cfg_valid = 0;
    logic [1:0] i_op = 0;
    logic signed [W-1:0] i_in_x = 0, i_in_y = 0, i_in_z = 0;
    logic [W-2:0] i_in_radius = 0;
    logic i_in_empty = 0, i_in_max = 0;
    logic [15:0] i_cfg_data = 0;
    logic o_stall, o_valid, o_is_empty, o_is_max, o_cfg_ready;
    logic signed [W-1:0] o_center_x, o_center_y, o_center_z;
    logic [W-2:0] o_radius;

    sphere_scoreboard sb = new();
    int unsigned idle_cycles = 0, cycle_no = 0, n_sent = 0, n_cfg = 0;
    bit fill_rx = 0;

    bounding_sphere_accumulate #(.COORD_WIDTH(W)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_in_x(i_in_x), .i_in_y(i_in_y), .i_in_z(i_in_z),
        .i_in_radius(i_in_radius), .i_in_empty(i_in_empty), .i_in_max(i_in_max),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_center_x(o_center_x), .o_center_y(o_center_y), .o_center_z(o_center_z),
        .o_radius(o_radius), .o_is_empty(o_is_empty), .o_is_max(o_is_max),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // output side: check beats, stall on a changing pattern
    always @(posedge i_clk) begin
        t_sphere got;
        int unsigned mode;
        if (i_rst_n && o_valid && !i_stall) begin
            got.x = o_center_x; got.y = o_center_y; got.z = o_center_z;
            got.r = o_radius; got.empty = o_is_empty; got.max = o_is_max;
            sb.check_sphere(got);
        end
        cycle_no <= cycle_no + 1;
        mode = (cycle_no / 97) % 4;
        case (mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= ((cycle_no % 8) < 5);
        endcase
    end

    // watchdog on cycles with no beat moving anywhere
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_operand(t_operand a);
        i_valid <= 1'b1;
        i_op <= a.op;
        i_in_x <= a.x; i_in_y <= a.y; i_in_z <= a.z;
        i_in_radius <= a.r; i_in_empty <= a.empty; i_in_max <= a.max;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_operand(a);
        n_sent++;
    endtask

    task automatic pause_input(int unsigned n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // tolerance write, only with the block idle
    task automatic write_tolerance(logic [15:0] v);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.tol = 64'(v);
        n_cfg++;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_operand mk(t_sphere_op op, int x, int y, int z,
                                    logic [W-2:0] r, logic e, logic m);
        t_operand a;
        a.op = op; a.x = x; a.y = y; a.z = z; a.r = r; a.empty = e; a.max = m;
        return a;
    endfunction

    function automatic logic signed [W-1:0] rand_coord(int unsigned scale);
        logic signed [W-1:0] v;
        v = $urandom;
        return v >>> scale;
    endfunction

    // mostly extends and merges around a cluster, with full-range outliers
    function automatic t_operand rand_operand();
        t_operand a;
        int unsigned sel, sc;
        sel = $urandom_range(0, 99);
        if (sel < 4) a.op = OP_CLEAR;
        else if (sel < 6) a.op = OP_NONE;
        else if (sel < 50) a.op = OP_EXTEND;
        else a.op = OP_MERGE;
        sc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 31);
        a.x = rand_coord(sc); a.y = rand_coord(sc); a.z = rand_coord(sc);
        a.r = (W-1)'(W'($urandom) >> $urandom_range(1, 31));
        a.empty = ($urandom_range(0, 14) == 0);
        a.max = ($urandom_range(0, 39) == 0);
        return a;
    endfunction

    initial begin
        t_operand q[$];
        int unsigned burst, k;
        logic [15:0] tols[4];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases at the reset tolerance
        q.push_back(mk(OP_MERGE, 5, 6, 7, 31'd9, 1, 0));
        q.push_back(mk(OP_NONE, 1, 1, 1, 31'd1, 0, 0));
        q.push_back(mk(OP_EXTEND, 32'h10000, 32'h20000, 32'h30000, 0, 0, 0));
        q.push_back(mk(OP_EXTEND, 32'h10000, 32'h20000, 32'h30000, 0, 0, 0));
        q.push_back(mk(OP_EXTEND, 32'h10001, 32'h20000, 32'h30000, 0, 0, 0));
        q.push_back(mk(OP_MERGE, 32'h10000, 32'h20000, 32'h30000, 31'h8000, 0, 0));
        q.push_back(mk(OP_MERGE, 0, 0, 0, 31'h100000, 0, 0));
        q.push_back(mk(OP_EXTEND, 32'h1000, 32'h2000, 0, 0, 0, 0));
        q.push_back(mk(OP_EXTEND, 32'h400000, 32'hffc00000, 32'h123456, 0, 0, 0));
        q.push_back(mk(OP_MERGE, 32'h80000000, 32'h80000000, 32'h80000000, RAD_MAX, 0, 0));
        q.push_back(mk(OP_EXTEND, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0));
        q.push_back(mk(OP_MERGE, 3, 3, 3, 31'd4, 1, 1));
        q.push_back(mk(OP_EXTEND, 9, 9, 9, 0, 0, 0));
        q.push_back(mk(OP_MERGE, 9, 9, 9, 31'd4, 0, 0));
        q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        q.push_back(mk(OP_MERGE, 32'h7fffffff, 32'h80000000, 0, RAD_MAX, 0, 0));
        q.push_back(mk(OP_EXTEND, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0, 0));
        q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        q.push_back(mk(OP_EXTEND, 0, 0, 0, 0, 0, 0));
        q.push_back(mk(OP_MERGE, 32'h30000, 0, 0, 31'h10000, 0, 0));
        q.push_back(mk(OP_MERGE, 32'h1000000, 0, 0, 31'h2000000, 0, 0));
        foreach (q[i]) send_operand(q[i]);

        tols[0] = 16'd0; tols[1] = 16'hffff; tols[2] = 16'($urandom); tols[3] = 16'd1;
        for (int ph = 0; ph < 4; ph++) begin
            write_tolerance(tols[ph]);
            k = 0;
            while (k < N_RANDOM / 4) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && k < N_RANDOM / 4; b++) begin
                    send_operand(rand_operand());
                    k++;
                end
                if (k == N_RANDOM / 8) drain();
                else if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 12));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d items over %0d tolerance settings, %0d output beats checked",
                 n_sent, n_cfg + 1, sb.checked);
        $display("grows %0d, covering %0d, covered %0d, coincident %0d, saturations %0d",
                 sb.n_grow, sb.n_cover, sb.n_covered, sb.n_coinc, sb.n_sat);
        if (sb.mismatches != 0 || sb.pending.size() != 0) begin
            $display("%0d mismatches, %0d beats missing", sb.mismatches, sb.pending.size());
            $display("*** FAILED ***");
        end else begin
            $display("*** PASSED ***");
        end
        $finish;
    end

endmodule
